// ----- src/tsct_pkg.sv -----
// Shared types, constants and helpers for the tab-separated cell tokenizer.
// No dependencies; every other file in src imports this package.
package tsct_pkg;

  // Width of the row, column and cursor counters; they saturate at all ones.
  localparam int POS_WIDTH = 16;
  // Width of the position fields carried on the result channel.
  localparam int FIELD_WIDTH = 16;

  // Queue between the classifier and the lexer; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] CHAR_QUOTE     = 8'd34;
  localparam logic [7:0] CHAR_BACKSLASH = 8'd92;
  localparam logic [7:0] CHAR_HIGH      = 8'd128;

  typedef logic [POS_WIDTH-1:0]   pos_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [2:0] {
    EV_TOKEN_BYTE = 3'd0,
    EV_TOKEN_END  = 3'd1,
    EV_BLANK_LINE = 3'd2,
    EV_LINE_END   = 3'd3,
    EV_BAD_CHAR   = 3'd4,
    EV_DROPPED    = 3'd5,
    EV_INPUT_END  = 3'd6
  } event_t;

  // Byte classes as seen by the lexer.
  typedef enum logic [2:0] {
    CLS_ZERO      = 3'd0,
    CLS_TAB       = 3'd1,
    CLS_NEWLINE   = 3'd2,
    CLS_QUOTE     = 3'd3,
    CLS_BACKSLASH = 3'd4,
    CLS_CONTROL   = 3'd5,
    CLS_PLAIN     = 3'd6
  } byte_class_t;

  typedef enum logic [5:0] {
    MODE_EXPECT  = 6'b000001,
    MODE_SIMPLE  = 6'b000010,
    MODE_LITERAL = 6'b000100,
    MODE_ESCAPE  = 6'b001000,
    MODE_CLOSED  = 6'b010000,
    MODE_HALTED  = 6'b100000
  } lex_mode_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  text_byte;
  } queue_entry_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] data;
    field_t     cell_row;
    field_t     cell_column;
    field_t     cursor_x;
    field_t     cursor_y;
    logic       fatal;
    logic       last;
  } result_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic result_t make_result(input event_t ev, input logic [7:0] d,
                                          input pos_t r, input pos_t c,
                                          input pos_t x, input pos_t y,
                                          input logic f);
    result_t res;
    res.event_res   = ev;
    res.data        = d;
    res.cell_row    = FIELD_WIDTH'(r);
    res.cell_column = FIELD_WIDTH'(c);
    res.cursor_x    = FIELD_WIDTH'(x);
    res.cursor_y    = FIELD_WIDTH'(y);
    res.fatal       = f;
    res.last        = 1'b0;
    return res;
  endfunction

endpackage

// ----- src/tsct_channels.sv -----
// Valid/ready channel interfaces for the text bytes and the result events.
// Depends on tsct_pkg for the payload types.
interface tsct_byte_if;
  import tsct_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface tsct_result_if;
  import tsct_pkg::*;
  logic       valid;
  logic       ready;
  event_t     event_res;
  logic [7:0] data;
  field_t     cell_row;
  field_t     cell_column;
  field_t     cursor_x;
  field_t     cursor_y;
  logic       fatal;
  logic       last;

  modport source (output valid, output event_res, output data, output cell_row,
                  output cell_column, output cursor_x, output cursor_y,
                  output fatal, output last, input ready);
  modport sink   (input valid, input event_res, input data, input cell_row,
                  input cell_column, input cursor_x, input cursor_y,
                  input fatal, input last, output ready);
endinterface

// ----- src/tab_separated_cell_tokenizer.sv -----
// Top level of the tab-separated cell tokenizer: front classifier, byte queue
// and lexer back end. Depends on tsct_pkg, tsct_channels and the tsct modules.
//
// The block takes one text byte per transaction on the text channel and
// delivers lexer events on the events channel, one event per transaction with
// last set on the final event caused by a byte. It sustains one byte per clock
// cycle as long as every byte causes at most one event and the sink keeps
// ready high; a byte that causes two events (token end plus line end, token
// dropped or fatal bad char plus input end) stalls the lexer until its second
// event moves from the spare slot into the output register, so the output
// register sets the rate in that case. A byte accepted on the text channel
// goes into the four-entry queue; the lexer takes it when the output register
// can load and registers its first event there. The queue lets the text side
// keep streaming for up to four bytes while the event side stalls. A zero byte
// ends the string and returns all lexer state to its reset value; no clearing
// pass is needed after reset. The control-byte option (cfg_data, reset 1) makes
// bytes 128 to 255 count as control bytes; it is written with cfg_write and
// should only change while no bytes are in flight.
module tab_separated_cell_tokenizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  tsct_byte_if.sink     text,
  tsct_result_if.source events
);
  import tsct_pkg::*;

  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         pop;
  logic         head_valid;
  queue_entry_t head_entry;

  // Front: option register and byte classification.
  tsct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .text       (text),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue that decouples byte acceptance from event delivery.
  tsct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Back: lexer state machine, counters and the output register.
  tsct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .events     (events)
  );

endmodule

// ----- src/tsct_front.sv -----
// Input side of the tokenizer: holds the control-byte option and classifies
// each accepted byte into a queue entry. Depends on tsct_pkg, tsct_channels.
module tsct_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  tsct_byte_if.sink             text,
  input  logic                  queue_full,
  output logic                  push,
  output tsct_pkg::queue_entry_t push_entry
);
  import tsct_pkg::*;

  logic high_bytes_are_control;
  logic is_control;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_bytes_are_control <= 1'b1;
    end else if (cfg_write) begin
      high_bytes_are_control <= cfg_data;
    end
  end

  assign is_control = (text.text_byte <= CHAR_SPACE) ||
                      (high_bytes_are_control && (text.text_byte >= CHAR_HIGH));

  always_comb begin
    push_entry.text_byte = text.text_byte;
    if (text.text_byte == 8'd0) begin
      push_entry.cls = CLS_ZERO;
    end else if (text.text_byte == CHAR_TAB) begin
      push_entry.cls = CLS_TAB;
    end else if (text.text_byte == CHAR_NEWLINE) begin
      push_entry.cls = CLS_NEWLINE;
    end else if (is_control) begin
      push_entry.cls = CLS_CONTROL;
    end else if (text.text_byte == CHAR_QUOTE) begin
      push_entry.cls = CLS_QUOTE;
    end else if (text.text_byte == CHAR_BACKSLASH) begin
      push_entry.cls = CLS_BACKSLASH;
    end else begin
      push_entry.cls = CLS_PLAIN;
    end
  end

  assign text.ready = !queue_full;
  assign push       = text.valid && !queue_full;

endmodule

// ----- src/tsct_queue.sv -----
// Small first-in first-out queue of classified bytes between front and back.
// Depends on tsct_pkg.
module tsct_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tsct_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output tsct_pkg::queue_entry_t head_entry
);
  import tsct_pkg::*;

  queue_entry_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

endmodule

// ----- src/tsct_back.sv -----
// Lexer state machine: takes classified bytes from the queue, keeps the row,
// column and cursor counters, and sends events out through an output register
// with one spare slot for a second event. Depends on tsct_pkg, tsct_channels.
module tsct_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  tsct_pkg::queue_entry_t head_entry,
  output logic                   pop,
  tsct_result_if.source          events
);
  import tsct_pkg::*;

  lex_mode_t mode, mode_next;
  pos_t      row_count, row_count_next;
  pos_t      column_count, column_count_next;
  pos_t      cursor_col, cursor_col_next;
  pos_t      cursor_line, cursor_line_next;
  logic      has_bytes, has_bytes_next;

  logic      out_valid;
  result_t   out_res;
  logic      pend_valid;
  result_t   pend_res;

  result_t    res0, res1;
  logic [1:0] res_count;
  logic       do_clear;
  logic       can_load;
  logic [7:0] c;

  assign c        = head_entry.text_byte;
  assign can_load = !out_valid || events.ready;
  assign pop      = head_valid && !pend_valid && can_load;

  always_comb begin
    mode_next         = mode;
    row_count_next    = row_count;
    column_count_next = column_count;
    cursor_col_next   = cursor_col;
    cursor_line_next  = cursor_line;
    has_bytes_next    = has_bytes;
    do_clear          = 1'b0;
    res_count         = 2'd0;
    res0 = make_result(EV_INPUT_END, 8'd0, '0, '0, '0, '0, 1'b0);
    res1 = res0;

    case (mode)
      MODE_EXPECT: begin
        case (head_entry.cls)
          CLS_ZERO: begin
            res_count = 2'd1;
            do_clear  = 1'b1;
          end
          CLS_TAB: begin
            column_count_next = sat_inc(column_count);
            cursor_col_next   = sat_inc(cursor_col);
          end
          CLS_NEWLINE: begin
            row_count_next    = sat_inc(row_count);
            column_count_next = pos_t'(1);
            cursor_col_next   = pos_t'(1);
            cursor_line_next  = sat_inc(cursor_line);
            res0 = make_result(EV_BLANK_LINE, 8'd0, '0, '0, pos_t'(1),
                               sat_inc(cursor_line), 1'b0);
            res_count = 2'd1;
          end
          CLS_CONTROL: begin
            res0 = make_result(EV_BAD_CHAR, c, '0, '0, cursor_col, cursor_line, 1'b0);
            res_count = 2'd1;
          end
          CLS_QUOTE: begin
            mode_next       = MODE_LITERAL;
            cursor_col_next = sat_inc(cursor_col);
          end
          default: begin
            mode_next       = MODE_SIMPLE;
            cursor_col_next = sat_inc(cursor_col);
            has_bytes_next  = 1'b1;
            res0 = make_result(EV_TOKEN_BYTE, c, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
        endcase
      end
      MODE_SIMPLE: begin
        case (head_entry.cls)
          CLS_ZERO: begin
            do_clear = 1'b1;
            if (has_bytes) begin
              res0 = make_result(EV_DROPPED, 8'd0, '0, '0, '0, '0, 1'b0);
              res_count = 2'd2;
            end else begin
              res_count = 2'd1;
            end
          end
          CLS_TAB: begin
            if (has_bytes) begin
              res0 = make_result(EV_TOKEN_END, 8'd0, row_count, column_count,
                                 '0, '0, 1'b0);
              res_count = 2'd1;
            end
            has_bytes_next    = 1'b0;
            cursor_col_next   = sat_inc(cursor_col);
            column_count_next = sat_inc(column_count);
            mode_next         = MODE_EXPECT;
          end
          CLS_NEWLINE: begin
            if (has_bytes) begin
              res0 = make_result(EV_TOKEN_END, 8'd0, row_count, column_count,
                                 '0, '0, 1'b0);
              res1 = make_result(EV_LINE_END, 8'd0, '0, '0, '0, '0, 1'b0);
              res_count = 2'd2;
            end else begin
              res0 = make_result(EV_LINE_END, 8'd0, '0, '0, '0, '0, 1'b0);
              res_count = 2'd1;
            end
            has_bytes_next    = 1'b0;
            row_count_next    = sat_inc(row_count);
            column_count_next = pos_t'(1);
            cursor_col_next   = pos_t'(1);
            cursor_line_next  = sat_inc(cursor_line);
            mode_next         = MODE_EXPECT;
          end
          CLS_CONTROL, CLS_QUOTE: begin
            // A stray byte inside a bare token aborts the whole string.
            res0 = make_result(EV_BAD_CHAR, c, '0, '0, cursor_col, cursor_line, 1'b1);
            res_count      = 2'd1;
            has_bytes_next = 1'b0;
            mode_next      = MODE_HALTED;
          end
          default: begin
            cursor_col_next = sat_inc(cursor_col);
            has_bytes_next  = 1'b1;
            res0 = make_result(EV_TOKEN_BYTE, c, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
        endcase
      end
      MODE_LITERAL: begin
        case (head_entry.cls)
          CLS_ZERO: begin
            res0 = make_result(EV_BAD_CHAR, 8'd0, '0, '0, cursor_col, cursor_line, 1'b1);
            res_count = 2'd2;
            do_clear  = 1'b1;
          end
          CLS_QUOTE: begin
            if (has_bytes) begin
              res0 = make_result(EV_TOKEN_END, 8'd0, row_count, column_count,
                                 '0, '0, 1'b0);
              res_count = 2'd1;
            end
            has_bytes_next  = 1'b0;
            cursor_col_next = sat_inc(cursor_col);
            mode_next       = MODE_CLOSED;
          end
          CLS_NEWLINE: begin
            // A newline inside quotes is data; only the cursor moves down.
            has_bytes_next   = 1'b1;
            cursor_col_next  = pos_t'(1);
            cursor_line_next = sat_inc(cursor_line);
            res0 = make_result(EV_TOKEN_BYTE, c, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
          CLS_BACKSLASH: begin
            mode_next       = MODE_ESCAPE;
            cursor_col_next = sat_inc(cursor_col);
          end
          default: begin
            has_bytes_next  = 1'b1;
            cursor_col_next = sat_inc(cursor_col);
            res0 = make_result(EV_TOKEN_BYTE, c, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
        endcase
      end
      MODE_ESCAPE: begin
        case (head_entry.cls)
          CLS_ZERO: begin
            res0 = make_result(EV_BAD_CHAR, 8'd0, '0, '0, cursor_col, cursor_line, 1'b1);
            res_count = 2'd2;
            do_clear  = 1'b1;
          end
          CLS_QUOTE, CLS_BACKSLASH: begin
            has_bytes_next  = 1'b1;
            mode_next       = MODE_LITERAL;
            cursor_col_next = sat_inc(cursor_col);
            res0 = make_result(EV_TOKEN_BYTE, c, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
          default: begin
            res0 = make_result(EV_BAD_CHAR, c, '0, '0, cursor_col, cursor_line, 1'b0);
            res_count = 2'd1;
          end
        endcase
      end
      MODE_CLOSED: begin
        case (head_entry.cls)
          CLS_ZERO: begin
            res_count = 2'd1;
            do_clear  = 1'b1;
          end
          CLS_TAB: begin
            cursor_col_next   = sat_inc(cursor_col);
            column_count_next = sat_inc(column_count);
            mode_next         = MODE_EXPECT;
          end
          CLS_NEWLINE: begin
            row_count_next    = sat_inc(row_count);
            column_count_next = pos_t'(1);
            cursor_col_next   = pos_t'(1);
            cursor_line_next  = sat_inc(cursor_line);
            mode_next         = MODE_EXPECT;
            res0 = make_result(EV_LINE_END, 8'd0, '0, '0, '0, '0, 1'b0);
            res_count = 2'd1;
          end
          default: begin
            res0 = make_result(EV_BAD_CHAR, c, '0, '0, cursor_col, cursor_line, 1'b0);
            res_count = 2'd1;
          end
        endcase
      end
      default: begin
        // Halted: everything up to the next zero byte is ignored.
        if (head_entry.cls == CLS_ZERO) begin
          res_count = 2'd1;
          do_clear  = 1'b1;
        end
      end
    endcase

    // The input end event is always the final one of a zero byte.
    if (do_clear) begin
      mode_next         = MODE_EXPECT;
      row_count_next    = pos_t'(1);
      column_count_next = pos_t'(1);
      cursor_col_next   = pos_t'(1);
      cursor_line_next  = pos_t'(1);
      has_bytes_next    = 1'b0;
    end

    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_EXPECT;
      row_count    <= pos_t'(1);
      column_count <= pos_t'(1);
      cursor_col   <= pos_t'(1);
      cursor_line  <= pos_t'(1);
      has_bytes    <= 1'b0;
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (pend_valid && can_load) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (pop) begin
        mode         <= mode_next;
        row_count    <= row_count_next;
        column_count <= column_count_next;
        cursor_col   <= cursor_col_next;
        cursor_line  <= cursor_line_next;
        has_bytes    <= has_bytes_next;
        out_valid    <= (res_count != 2'd0);
        pend_valid   <= (res_count == 2'd2);
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && can_load) begin
      out_res <= pend_res;
    end else if (pop && (res_count != 2'd0)) begin
      out_res  <= res0;
      pend_res <= res1;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_res   = out_res.event_res;
  assign events.data        = out_res.data;
  assign events.cell_row    = out_res.cell_row;
  assign events.cell_column = out_res.cell_column;
  assign events.cursor_x    = out_res.cursor_x;
  assign events.cursor_y    = out_res.cursor_y;
  assign events.fatal       = out_res.fatal;
  assign events.last        = out_res.last;

endmodule
